// File: hdl/servo_move_interpolator_core_defines.svh
// ----------------------------------------------------------------------------
// Servo move interpolator assertion macros
// Shared concurrent assertion helpers for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef SERVO_MOVE_INTERPOLATOR_CORE_DEFINES_SVH
`define SERVO_MOVE_INTERPOLATOR_CORE_DEFINES_SVH

// assert that antecedent implies consequent in the same cycle
`define SMI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// assert that antecedent implies consequent in the next cycle
`define SMI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/smi_pkg.sv
// ----------------------------------------------------------------------------
// Servo move interpolator package
// Shared types and constants.
// ----------------------------------------------------------------------------
package smi_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_ACK    = 1'b1;

  localparam logic [1:0] REG_TICK    = 2'd0;
  localparam logic [1:0] REG_GRIPMIN = 2'd1;
  localparam logic [1:0] REG_GRIPMAX = 2'd2;

  // pi * 2^61, truncated
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  localparam int DIV_BITS = 64;

  typedef struct packed {
    logic        start;
    logic [63:0] num_mag;
    logic [63:0] den_mag;
    logic        neg;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;  // rounded magnitude
    logic        neg;
  } div_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat32 = 32'h7fffffff;
    else if (v < -66'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

// File: hdl/smi_divider.sv
// ----------------------------------------------------------------------------
// Servo move interpolator divider
// Radix-2 restoring divider, one quotient bit per cycle; the caller's den/2 bias rounds half away.
// ----------------------------------------------------------------------------
module smi_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smi_pkg::div_req_t req_i,
  output smi_pkg::div_rsp_t rsp_o
);
  import smi_pkg::*;

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [64:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (req_i.start) begin
      // numerator already biased by den/2
      rem_d  = '0;
      quo_d  = req_i.num_mag;
      den_d  = req_i.den_mag;
      neg_d  = req_i.neg;
      cnt_d  = 7'(DIV_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.neg  = neg_q;

endmodule

// File: hdl/servo_move_interpolator_core.sv
// ----------------------------------------------------------------------------
// Servo move interpolator core
// Seven-joint linear move interpolator with one shared serial divider.
// ----------------------------------------------------------------------------
// A tick visits each joint in turn: a joint with time left goes through setup,
// multiply, a divide, write-back and report, while a finished joint goes
// straight to its report; any joint also waits while the previous report is
// still unaccepted. A command runs its target divide, then refreshes the
// distance of each joint in turn and then gives the acknowledge; a bad joint is acknowledged in
// the cycle after its transfer. The serial divider yields one quotient bit per
// cycle. The block takes one item at a time and is not
// ready while it works or while a result waits.
module servo_move_interpolator_core #(
  parameter int NUM_JOINTS    = 7,
  parameter int POS_FRAC_BITS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [3:0]  joint_i,
  input  logic [15:0] pulse_width_i,
  input  logic [15:0] move_time_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [2:0]  joint_out_o,
  output logic signed [31:0] position_o,
  output logic        status_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import smi_pkg::*;

  localparam int JW = $clog2(NUM_JOINTS);
  localparam int GRIP_L = 5;
  localparam int GRIP_R = 6;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_TSET  = 8'b00000010,
    S_TMUL  = 8'b00000100,
    S_TDIV  = 8'b00001000,
    S_TOUT  = 8'b00010000,
    S_CDIV  = 8'b00100000,
    S_CUPD  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_e;

  state_e state_q;

  logic [9:0]  tick_q;
  logic [15:0] gmin_q, gmax_q;

  logic [31:0] tgt_q [NUM_JOINTS];
  logic [31:0] cur_q [NUM_JOINTS];
  logic [31:0] dlt_q [NUM_JOINTS];
  logic [15:0] mt_q  [NUM_JOINTS];
  logic [16:0] el_q  [NUM_JOINTS];

  logic [3:0]  jnt_q;
  logic [15:0] pw_q, mtin_q;
  logic [JW:0] idx_q;
  logic signed [63:0] prod_q;

  logic        ov_q, okind_q, ostat_q, olast_q;
  logic [2:0]  ojnt_q;
  logic [31:0] opos_q;

  div_req_t dreq;
  div_rsp_t drsp;

  smi_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [JW-1:0] ix;
  assign ix = idx_q[JW-1:0];

  logic signed [65:0] qsig;
  assign qsig = drsp.neg ? -$signed({2'b0, drsp.quo}) : $signed({2'b0, drsp.quo});

  // command numerator/denominator (signed)
  logic signed [63:0] cnum, cden, piq;
  logic signed [17:0] pwd;
  logic signed [18:0] gsum;
  logic               grip, dzero;
  always_comb begin
    piq   = $signed(64'(PI_Q61 >> (49 - POS_FRAC_BITS)));
    pwd   = $signed({2'b0, pw_q}) - 18'sd1500;
    grip  = (jnt_q == 4'(GRIP_L));
    gsum  = $signed({2'b0, pw_q, 1'b0}) - $signed({3'b0, gmin_q}) - $signed({3'b0, gmax_q});
    cden  = 64'sd200 * ($signed({48'b0, gmax_q}) - $signed({48'b0, gmin_q}));
    dzero = (gmax_q == gmin_q);
    if (!grip) begin
      cnum = 64'(pwd) * piq;
      cden = 64'sd8192000;
    end else if (dzero) begin
      cnum = -(64'sd3 <<< POS_FRAC_BITS);
      cden = 64'sd200;
    end else begin
      cnum = (64'sd3 * 64'(gsum)) <<< POS_FRAC_BITS;
    end
  end

  // cmd divide launch happens from S_CDIV entry cycle flag
  logic cstart_q;

  logic [63:0] n_mag, d_mag, t_num, t_den;
  logic        t_neg;

  always_comb begin
    if (state_q == S_TMUL) begin
      t_num = prod_q;
      t_den = {48'b0, mt_q[ix]};
    end else begin
      t_num = cnum;
      t_den = cden;
    end
    t_neg = (t_num[63] != t_den[63]);
    n_mag = t_num[63] ? -t_num : t_num;
    d_mag = t_den[63] ? -t_den : t_den;
    dreq.start   = (state_q == S_TMUL) || cstart_q;
    dreq.num_mag = n_mag + (d_mag >> 1);
    dreq.den_mag = d_mag;
    dreq.neg     = t_neg;
  end

  logic out_free;
  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && !ov_q;
  assign cfg_ready_o = 1'b1;

  logic jok;
  assign jok = ({1'b0, joint_i} < 5'(NUM_JOINTS));

  // result register is loaded this cycle
  logic load_out;
  assign load_out = (in_valid_i && in_ready_o && (op_i == OP_MOVE) && !jok) ||
                    ((state_q == S_TOUT || state_q == S_OUT) && out_free);

  logic signed [65:0] sum;
  assign sum = $signed({{34{cur_q[ix][31]}}, cur_q[ix]}) + qsig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tick_q   <= 10'd10;
      gmin_q   <= 16'd500;
      gmax_q   <= 16'd2500;
      ov_q     <= 1'b0;
      idx_q    <= '0;
      cstart_q <= 1'b0;
      for (int i = 0; i < NUM_JOINTS; i++) begin
        tgt_q[i] <= '0;
        cur_q[i] <= '0;
        dlt_q[i] <= '0;
        mt_q[i]  <= '0;
        el_q[i]  <= '0;
      end
    end else begin
      cstart_q <= 1'b0;
      if (load_out) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TICK:    tick_q <= cfg_data_i[9:0];
          REG_GRIPMIN: gmin_q <= cfg_data_i;
          REG_GRIPMAX: gmax_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            jnt_q  <= joint_i;
            pw_q   <= pulse_width_i;
            mtin_q <= move_time_ms_i;
            idx_q  <= '0;
            if (op_i == OP_TICK) state_q <= S_TSET;
            else if (jok) begin
              state_q  <= S_CDIV;
              cstart_q <= 1'b1;
            end else begin
              okind_q <= KIND_ACK;
              ojnt_q  <= joint_i[2:0];
              opos_q  <= '0;
              ostat_q <= 1'b1;
              olast_q <= 1'b1;
            end
          end
        end
        S_TSET: begin
          if (el_q[ix] < {1'b0, mt_q[ix]}) begin
            prod_q  <= $signed(dlt_q[ix]) * $signed({1'b0, tick_q});
            state_q <= S_TMUL;
          end else state_q <= S_TOUT;
        end
        S_TMUL: state_q <= S_TDIV;
        S_TDIV: begin
          if (drsp.done) begin
            cur_q[ix] <= sat32(sum);
            el_q[ix]  <= el_q[ix] + {7'b0, tick_q};
            state_q   <= S_TOUT;
          end
        end
        S_TOUT: begin
          if (out_free) begin
            okind_q <= KIND_REPORT;
            ojnt_q  <= 3'(idx_q);
            opos_q  <= cur_q[ix];
            ostat_q <= 1'b0;
            olast_q <= (idx_q == (JW+1)'(NUM_JOINTS - 1));
            if (idx_q == (JW+1)'(NUM_JOINTS - 1)) state_q <= S_IDLE;
            else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_TSET;
            end
          end
        end
        S_CDIV: begin
          if (drsp.done) begin
            mt_q[jnt_q[JW-1:0]]  <= mtin_q;
            tgt_q[jnt_q[JW-1:0]] <= sat32(qsig);
            if (grip) begin
              mt_q[JW'(GRIP_R)]  <= mtin_q;
              tgt_q[JW'(GRIP_R)] <= sat32(qsig);
            end
            idx_q   <= '0;
            state_q <= S_CUPD;
          end
        end
        S_CUPD: begin
          dlt_q[ix] <= sat32($signed({{34{tgt_q[ix][31]}}, tgt_q[ix]}) -
                             $signed({{34{cur_q[ix][31]}}, cur_q[ix]}));
          el_q[ix]  <= '0;
          if (idx_q == (JW+1)'(NUM_JOINTS - 1)) state_q <= S_OUT;
          else idx_q <= idx_q + 1'b1;
        end
        S_OUT: begin
          if (out_free) begin
            okind_q <= KIND_ACK;
            ojnt_q  <= jnt_q[2:0];
            opos_q  <= tgt_q[jnt_q[JW-1:0]];
            ostat_q <= 1'b0;
            olast_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o      = okind_q;
  assign joint_out_o = ojnt_q;
  assign position_o  = opos_q;
  assign status_o    = ostat_q;
  assign last_o      = olast_q;

`include "servo_move_interpolator_core_defines.svh"
  `SMI_ASSERT_IMP(a_idle_ready, in_ready_o, state_q == S_IDLE)
  `SMI_ASSERT_NXT(a_hold_out, out_valid_o && !out_ready_i, out_valid_o && $stable(position_o))
  `SMI_ASSERT_IMP(a_div_state, drsp.busy, state_q == S_TDIV || state_q == S_CDIV)

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Servo move interpolator testbench
// Drives move commands and ticks through the valid/ready channels, predicts
// the acknowledges and per-joint position reports, and checks every transfer.
// ----------------------------------------------------------------------------
module testbench;
  import smi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJ = 7;
  localparam int FRAC = 28;
  localparam int GRIP_L = 5;
  localparam int GRIP_R = 6;

  typedef struct packed {
    logic        op;
    logic [3:0]  joint;
    logic [15:0] pw;
    logic [15:0] mt;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  joint;
    logic [31:0] pos;
    logic        status;
    logic        last;
  } rpt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = 1'b0;
  logic [3:0] joint_i = '0;
  logic [15:0] pulse_width_i = '0;
  logic [15:0] move_time_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic kind_o;
  logic [2:0] joint_out_o;
  logic signed [31:0] position_o;
  logic status_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  servo_move_interpolator_core u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [9:0]  tick_ms = 10;
  logic [15:0] grip_min = 500;
  logic [15:0] grip_max = 2500;
  logic signed [31:0] tgt [NJ];
  logic signed [31:0] cur [NJ];
  logic signed [31:0] togo [NJ];
  logic [15:0] mtime [NJ];
  logic [16:0] elap [NJ];

  cmd_t pending_cmds[$];
  rpt_t expected_rpts[$];
  int   fail_cnt = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  bit   hold_send = 1'b0;

  function automatic logic [31:0] clip32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] rdiv(input logic signed [127:0] num,
                                               input logic signed [127:0] den);
    logic neg;
    logic [127:0] un, ud, q;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (un + ud / 2) / ud;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] angle_of(input logic [15:0] pw);
    logic signed [127:0] d, piq;
    d = $signed({112'd0, pw}) - 1500;
    piq = $signed({64'd0, PI_Q61 >> (49 - FRAC)});
    return clip32(rdiv(d * piq, 8192000));
  endfunction

  function automatic logic [31:0] meters_of(input logic [15:0] pw);
    logic signed [127:0] one, den, num;
    one = 128'sd1 <<< FRAC;
    den = 200 * ($signed({112'd0, grip_max}) - $signed({112'd0, grip_min}));
    num = 3 * (2 * $signed({112'd0, pw}) - $signed({112'd0, grip_min})
               - $signed({112'd0, grip_max})) * one;
    if (den == 0) return clip32(rdiv(-3 * one, 200));
    return clip32(rdiv(num, den));
  endfunction

  function automatic void predict_item(input cmd_t c);
    rpt_t r;
    logic signed [127:0] stp;
    if (c.op == OP_MOVE) begin
      r = '{kind: KIND_ACK, joint: c.joint[2:0], pos: '0, status: 1'b1, last: 1'b1};
      if (c.joint < NJ) begin
        r.status = 1'b0;
        mtime[c.joint] = c.mt;
        if (c.joint == GRIP_L) begin
          tgt[GRIP_L] = meters_of(c.pw);
          tgt[GRIP_R] = tgt[GRIP_L];
          mtime[GRIP_R] = c.mt;
        end else begin
          tgt[c.joint] = angle_of(c.pw);
        end
        for (int i = 0; i < NJ; i++) begin
          togo[i] = clip32(128'(tgt[i]) - 128'(cur[i]));
          elap[i] = '0;
        end
        r.pos = tgt[c.joint];
      end
      expected_rpts.push_back(r);
    end else begin
      for (int i = 0; i < NJ; i++) begin
        if ({15'd0, elap[i]} < {16'd0, mtime[i]}) begin
          stp = rdiv(128'(togo[i]) * $signed({118'd0, tick_ms}),
                     $signed({112'd0, mtime[i]}));
          cur[i] = clip32(128'(cur[i]) + stp);
          elap[i] = elap[i] + tick_ms;
        end
        r = '{kind: KIND_REPORT, joint: 3'(i), pos: cur[i], status: 1'b0,
              last: (i == NJ - 1)};
        expected_rpts.push_back(r);
      end
    end
  endfunction

  // driver: items are predicted at their transfer
  always @(posedge clk_i) begin
    cmd_t c;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_item({op_i, joint_i, pulse_width_i, move_time_ms_i});
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          c = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          op_i <= c.op;
          joint_i <= c.joint;
          pulse_width_i <= c.pw;
          move_time_ms_i <= c.mt;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rpt_t e, a;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        a = '{kind_o, joint_out_o, position_o, status_o, last_o};
        if (expected_rpts.size() == 0) begin
          $display("%0t unexpected result: %p", $time, a);
          fail_cnt++;
        end else begin
          e = expected_rpts.pop_front();
          if (a.kind !== e.kind)
            $display("%0t kind: expected %0d actual %0d", $time, e.kind, a.kind);
          if (a.joint !== e.joint)
            $display("%0t joint_out: expected %0d actual %0d", $time, e.joint, a.joint);
          if (a.pos !== e.pos)
            $display("%0t position: expected %h actual %h", $time, e.pos, a.pos);
          if (a.status !== e.status)
            $display("%0t status: expected %0d actual %0d", $time, e.status, a.status);
          if (a.last !== e.last)
            $display("%0t last: expected %0d actual %0d", $time, e.last, a.last);
          if (a !== e) fail_cnt++;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic cmd_t rand_move();
    cmd_t c;
    c.op = OP_MOVE;
    c.joint = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 7)) : 4'($urandom_range(6));
    case ($urandom_range(3))
      0: c.pw = 16'($urandom);
      default: c.pw = 16'($urandom_range(2600, 400));
    endcase
    case ($urandom_range(5))
      0: c.mt = 16'($urandom);
      1: c.mt = 16'd0;
      default: c.mt = 16'($urandom_range(200, 1));
    endcase
    return c;
  endfunction

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid_i || expected_rpts.size() > 0)
      @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_TICK:    tick_ms = val[9:0];
      REG_GRIPMIN: grip_min = val;
      REG_GRIPMAX: grip_max = val;
      default: ;
    endcase
  endtask

  task automatic run_random(input int n);
    cmd_t c;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(2) == 0) c = rand_move();
      else c = '{op: OP_TICK, joint: 4'($urandom), pw: 16'($urandom), mt: 16'($urandom)};
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    for (int i = 0; i < NJ; i++) begin
      tgt[i] = '0; cur[i] = '0; togo[i] = '0; mtime[i] = '0; elap[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 29;
    recv_idle = 61;

    // directed: extremes, gripper, bad joints, zero move time
    pending_cmds.push_back('{OP_MOVE, 4'd0, 16'd0, 16'd30});
    pending_cmds.push_back('{OP_MOVE, 4'd1, 16'hffff, 16'hffff});
    pending_cmds.push_back('{OP_MOVE, 4'd2, 16'd1500, 16'd0});
    pending_cmds.push_back('{OP_MOVE, 4'd5, 16'd2500, 16'd40});
    pending_cmds.push_back('{OP_MOVE, 4'd7, 16'd1234, 16'd50});
    pending_cmds.push_back('{OP_MOVE, 4'd15, 16'hffff, 16'hffff});
    pending_cmds.push_back('{OP_MOVE, 4'd6, 16'd500, 16'd20});
    pending_cmds.push_back('{OP_MOVE, 4'd3, 16'd2000, 16'd1});
    pending_cmds.push_back('{OP_MOVE, 4'd4, 16'd1000, 16'd25});
    repeat (6) pending_cmds.push_back('{OP_TICK, 4'hf, 16'hffff, 16'hffff});
    pending_cmds.push_back('{OP_MOVE, 4'd8, 16'd0, 16'd0});
    pending_cmds.push_back('{OP_TICK, 4'd0, 16'd0, 16'd0});
    drain();

    // gripper limits: equal, inverted, extremes; long tick period
    write_reg(REG_GRIPMIN, 16'd1000);
    write_reg(REG_GRIPMAX, 16'd1000);
    pending_cmds.push_back('{OP_MOVE, 4'd5, 16'd1700, 16'd10});
    pending_cmds.push_back('{OP_TICK, 4'd0, 16'd0, 16'd0});
    drain();
    write_reg(REG_GRIPMIN, 16'hffff);
    write_reg(REG_GRIPMAX, 16'd0);
    write_reg(REG_TICK, 16'd1023);
    pending_cmds.push_back('{OP_MOVE, 4'd5, 16'hffff, 16'd3000});
    pending_cmds.push_back('{OP_MOVE, 4'd5, 16'd0, 16'd3000});
    run_random(110);
    drain();

    send_idle = 61;
    recv_idle = 29;
    write_reg(REG_TICK, 16'd1);
    write_reg(REG_GRIPMIN, 16'd0);
    write_reg(REG_GRIPMAX, 16'hffff);
    run_random(110);
    // sender holds off until every result is in
    hold_send = 1'b1;
    while (in_valid_i || expected_rpts.size() > 0) @(posedge clk_i);
    hold_send = 1'b0;
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_TICK, 16'd0);
    write_reg(REG_GRIPMIN, 16'd500);
    write_reg(REG_GRIPMAX, 16'd2500);
    run_random(50);
    drain();
    write_reg(REG_TICK, 16'd1000);
    run_random(80);
    drain();
    write_reg(REG_TICK, 16'd10);
    run_random(80);
    drain();

    if (fail_cnt == 0 && expected_rpts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/smi_pkg.sv
hdl/smi_divider.sv
hdl/servo_move_interpolator_core.sv
sim/testbench.sv
